### rtl/cmct_pkg.sv
// ----------------------------------------------------------------------------
// cmct_pkg
// Shared constants and types of the context model counter table.
// ----------------------------------------------------------------------------
package cmct_pkg;

    // Model order and symbol size; the item port widths below are literals, not derived from them.
    localparam int ORDER          = 3;
    localparam int SYMBOL_BITS    = 4;
    localparam int COUNT_BITS_DEF = 32;

    // Port widths fixed by the field definitions.
    localparam int SYM_W   = 4;
    localparam int CTX_W   = 12;
    localparam int PROB_W  = 16;
    localparam int OUT_W   = 32;
    localparam int ALPHA_W = 16;
    localparam int DIV_W   = 8;
    localparam int ASIZE_W = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ASIZE   = 2'd2;

    // Command codes.
    localparam logic CMD_TRAIN = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_FILL,
        OP_COUNT,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [SYM_W-1:0]   symbol;
        logic [CTX_W-1:0]   ctx;
    } job_t;

endpackage

### rtl/cmct_front.sv
// ----------------------------------------------------------------------------
// cmct_front
// Accepts items, keeps the training history and queues classified jobs.
// ----------------------------------------------------------------------------
module cmct_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [cmct_pkg::SYM_W-1:0] symbol,
    input  logic                      start_of_stream,
    input  logic [cmct_pkg::CTX_W-1:0] query_context,
    output logic                      job_valid,
    input  logic                      job_ready,
    output cmct_pkg::job_t            job
);
    import cmct_pkg::*;

    localparam int HB = ORDER * SYMBOL_BITS;
    localparam int QD = 2;

    logic [HB-1:0]          history_reg;
    logic [2:0]             fill_reg;
    job_t                   q_reg [QD];
    logic                   wp_reg, rp_reg;
    logic [1:0]             cnt_reg;
    logic [SYMBOL_BITS-1:0] sym;
    logic [HB-1:0]          shifted;
    job_t                   new_job;
    logic                   push, pop;

    assign sym      = symbol[SYMBOL_BITS-1:0];
    assign shifted  = (HB > SYMBOL_BITS) ?
                      HB'({history_reg, sym}) : HB'(sym);
    assign in_ready = (cnt_reg != 2'(QD));
    assign push     = in_valid && in_ready;
    assign pop      = job_valid && job_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job      = q_reg[rp_reg];

    // Classify the incoming item.
    always_comb
    begin
        new_job.symbol = SYM_W'(sym);
        new_job.ctx    = CTX_W'(query_context[HB-1:0]);
        if (cmd == CMD_QUERY)
        begin
            new_job.op = OP_QUERY;
        end
        else if (start_of_stream || fill_reg < 3'(ORDER))
        begin
            new_job.op = OP_FILL;
        end
        else
        begin
            new_job.op  = OP_COUNT;
            new_job.ctx = CTX_W'(history_reg);
        end
    end

    // History and job queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
            fill_reg    <= '0;
            wp_reg      <= 1'b0;
            rp_reg      <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wp_reg] <= new_job;
                wp_reg        <= ~wp_reg;
                if (cmd == CMD_TRAIN)
                begin
                    if (start_of_stream)
                    begin
                        history_reg <= HB'(sym);
                        fill_reg    <= 3'd1;
                    end
                    else
                    begin
                        history_reg <= shifted;
                        if (fill_reg < 3'(ORDER))
                        begin
                            fill_reg <= fill_reg + 3'd1;
                        end
                    end
                end
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### rtl/cmct_divider.sv
// ----------------------------------------------------------------------------
// cmct_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmct_divider #(
    parameter int NW = 56,
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] n_reg;
    logic          busy_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};
    assign quo   = q_reg;

    // Shift and subtract.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
                n_reg    <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NW-2:0], 1'b0};
                end
                n_reg <= n_reg - CW'(1);
                if (n_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/cmct_back.sv
// ----------------------------------------------------------------------------
// cmct_back
// Executes jobs against the count table: increments, reductions, queries.
// ----------------------------------------------------------------------------
module cmct_back #(
    parameter int COUNT_BITS  = cmct_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  cmct_pkg::job_t                 job,
    input  logic [cmct_pkg::ALPHA_W-1:0]   alpha,
    input  logic [cmct_pkg::DIV_W-1:0]     divisor,
    input  logic [cmct_pkg::ASIZE_W-1:0]   asize,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cmct_pkg::PROB_W-1:0]    probability,
    output logic [cmct_pkg::OUT_W-1:0]     event_count,
    output logic [cmct_pkg::OUT_W-1:0]     context_total,
    output logic                           zero_denominator,
    output logic                           table_reduced
);
    import cmct_pkg::*;

    localparam int HB    = ORDER * SYMBOL_BITS;
    localparam int AB    = HB + SYMBOL_BITS;
    localparam int DEPTH = 1 << AB;
    localparam int NSYM  = 1 << SYMBOL_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam int SMW   = ALPHA_W + ASIZE_W;
    localparam int NUMW  = COUNT_BITS + 9 + 16;
    localparam int DENW  = ((COUNT_BITS + 8 > SMW) ? COUNT_BITS + 8 : SMW) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WAIT, S_INC, S_RED_RD, S_RED_WAIT,
        S_RED_DIV, S_RED_WR, S_Q_CE, S_Q_RD, S_Q_ACC, S_Q_DIVC, S_DIV,
        S_DIV_WAIT, S_OUT
    } state_t;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [AB-1:0]         raddr, waddr;
    logic                  we;
    logic [COUNT_BITS-1:0] wdata;

    state_t                state_reg;
    logic [AB:0]           ptr_reg;
    logic [AB-1:0]         idx_reg;
    job_t                  job_reg;
    logic [COUNT_BITS-1:0] ce_reg, tot_reg, val_reg, cnt_inc_reg;
    logic [SYMBOL_BITS:0]  s_reg;
    logic                  pend_reg, red_flag_reg;
    logic [COUNT_BITS-1:0] dq_reg;
    logic [COUNT_BITS-1:0] dr_reg;
    logic [5:0]            db_reg;
    logic [1:0]            dsel_reg;
    logic [DIV_W-1:0]      deff;

    // Division signals: the inline divide serves reductions and overflow scaling.
    logic [COUNT_BITS:0]   dtrial;
    logic                  dstart, ddone;
    logic [NUMW-1:0]       pnum;
    logic [DENW-1:0]       pden;
    logic [NUMW-1:0]       pquo;
    logic [SMW-1:0]        smooth_den;

    assign deff   = (divisor == '0) ? DIV_W'(1) : divisor;
    assign dtrial = {dr_reg, dq_reg[COUNT_BITS-1]};
    assign job_ready = (state_reg == S_IDLE) && !out_valid;

    // Table memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        raddr = idx_reg;
        if (state_reg == S_RED_RD)
        begin
            raddr = ptr_reg[AB-1:0];
        end
        else if (state_reg == S_Q_RD)
        begin
            raddr = AB'({job_reg.ctx[HB-1:0], s_reg[SYMBOL_BITS-1:0]});
        end
        we    = 1'b0;
        waddr = idx_reg;
        wdata = cnt_inc_reg;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = ptr_reg[AB-1:0];
            wdata = '0;
        end
        else if (state_reg == S_INC)
        begin
            we = 1'b1;
        end
        else if (state_reg == S_RED_WR)
        begin
            we    = 1'b1;
            waddr = ptr_reg[AB-1:0];
            wdata = dq_reg;
        end
    end

    assign smooth_den = SMW'(alpha) * SMW'(asize);
    assign pnum = {((COUNT_BITS+9)'(ce_reg) << 8) + (COUNT_BITS+9)'(alpha), 16'd0};
    assign pden = (DENW'(tot_reg) << 8) + DENW'(smooth_den);
    assign dstart = (state_reg == S_DIV);

    cmct_divider #(.NW(NUMW), .DW(DENW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (pnum),
        .den   (pden),
        .done  (ddone),
        .quo   (pquo)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            out_valid <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + (AB+1)'(1);
                    if (ptr_reg[AB-1:0] == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        job_reg          <= job;
                        idx_reg          <= AB'({job.ctx[HB-1:0],
                                                 job.symbol[SYMBOL_BITS-1:0]});
                        probability      <= '0;
                        event_count      <= '0;
                        context_total    <= '0;
                        zero_denominator <= 1'b0;
                        table_reduced    <= 1'b0;
                        s_reg            <= '0;
                        tot_reg          <= '0;
                        pend_reg         <= 1'b0;
                        dsel_reg         <= 2'd0;
                        case (job.op)
                            OP_FILL:  state_reg <= S_OUT;
                            OP_COUNT: state_reg <= S_RD;
                            OP_QUERY: state_reg <= S_Q_CE;
                            default:  state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    cnt_inc_reg <= (rdata_reg == CMAX) ? rdata_reg
                                                       : rdata_reg + COUNT_BITS'(1);
                    state_reg   <= S_INC;
                end
                S_INC:
                begin
                    event_count <= OUT_W'(cnt_inc_reg);
                    if (cnt_inc_reg == CMAX)
                    begin
                        table_reduced <= 1'b1;
                        ptr_reg       <= '0;
                        state_reg     <= S_RED_RD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_RED_RD:
                begin
                    state_reg <= S_RED_WAIT;
                end
                S_RED_WAIT:
                begin
                    dq_reg    <= rdata_reg;
                    dr_reg    <= '0;
                    db_reg    <= 6'(COUNT_BITS);
                    dsel_reg  <= 2'd0;
                    state_reg <= S_RED_DIV;
                end
                S_RED_DIV, S_Q_DIVC:
                begin
                    // One quotient bit per cycle by the effective divisor.
                    if (dtrial >= (COUNT_BITS+1)'(deff))
                    begin
                        dr_reg <= COUNT_BITS'(dtrial - (COUNT_BITS+1)'(deff));
                        dq_reg <= {dq_reg[COUNT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg <= COUNT_BITS'(dtrial);
                        dq_reg <= {dq_reg[COUNT_BITS-2:0], 1'b0};
                    end
                    db_reg <= db_reg - 6'd1;
                    if (db_reg == 6'd1)
                    begin
                        state_reg <= (state_reg == S_RED_DIV) ? S_RED_WR : S_Q_ACC;
                    end
                end
                S_RED_WR:
                begin
                    if (ptr_reg[AB-1:0] == idx_reg)
                    begin
                        event_count <= OUT_W'(dq_reg);
                    end
                    ptr_reg <= ptr_reg + (AB+1)'(1);
                    state_reg <= (ptr_reg[AB-1:0] == '1) ? S_OUT : S_RED_RD;
                end
                S_Q_CE:
                begin
                    // The queried count is read before summation starts.
                    state_reg <= S_Q_RD;
                end
                S_Q_RD:
                begin
                    if (s_reg == '0)
                    begin
                        ce_reg <= rdata_reg;
                    end
                    if (s_reg == (SYMBOL_BITS+1)'(NSYM))
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        pend_reg  <= 1'b1;
                        state_reg <= S_Q_ACC;
                    end
                end
                S_Q_ACC:
                begin
                    // Wait for read data, then check for overflow.
                    if (pend_reg)
                    begin
                        pend_reg <= 1'b0;
                        val_reg  <= rdata_reg;
                        if (tot_reg >= CMAX - rdata_reg)
                        begin
                            dq_reg       <= tot_reg;
                            dr_reg       <= '0;
                            db_reg       <= 6'(COUNT_BITS);
                            dsel_reg     <= 2'd1;
                            red_flag_reg <= 1'b1;
                            state_reg    <= S_Q_DIVC;
                        end
                        else
                        begin
                            red_flag_reg <= 1'b0;
                        end
                    end
                    else if (dsel_reg == 2'd1 && red_flag_reg)
                    begin
                        // Total divided; now divide the queried count.
                        tot_reg   <= dq_reg;
                        dq_reg    <= ce_reg;
                        dr_reg    <= '0;
                        db_reg    <= 6'(COUNT_BITS);
                        dsel_reg  <= 2'd2;
                        state_reg <= S_Q_DIVC;
                    end
                    else
                    begin
                        if (dsel_reg == 2'd2)
                        begin
                            ce_reg <= dq_reg;
                        end
                        dsel_reg     <= 2'd0;
                        red_flag_reg <= 1'b0;
                        begin : add_blk
                            logic [COUNT_BITS:0] sum;
                            logic [COUNT_BITS-1:0] t;
                            t   = (dsel_reg == 2'd2) ? tot_reg : tot_reg;
                            sum = {1'b0, t} + {1'b0, val_reg};
                            tot_reg <= sum[COUNT_BITS] ? CMAX : sum[COUNT_BITS-1:0];
                        end
                        s_reg     <= s_reg + (SYMBOL_BITS+1)'(1);
                        state_reg <= S_Q_RD;
                    end
                end
                S_DIV:
                begin
                    event_count   <= OUT_W'(ce_reg);
                    context_total <= OUT_W'(tot_reg);
                    if (pden == '0)
                    begin
                        zero_denominator <= 1'b1;
                        state_reg        <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (ddone)
                    begin
                        probability <= (pquo > NUMW'(16'hFFFF)) ? 16'hFFFF : pquo[15:0];
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/context_model_counter_table_top.sv
// ----------------------------------------------------------------------------
// context_model_counter_table_top
// Order-k finite-context counting model with smoothed probability queries.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready (cmd, symbol, start_of_stream,
// query_context); one result per item leaves on out_valid/out_ready.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data,
// and are taken in any cycle.
// A front end keeps the training history and queues classified jobs in a
// two-entry queue; a back end runs them on a simple dual-port count memory.
// Fill items go straight to the result; counted train items read, increment
// and write back their count; queries fetch the queried count, sum the
// counts of all 16 symbols of the context, then run the bit-serial divider;
// an overflow in summation adds two divides, of the total and of the count.
// A table reduction walks all entries, dividing each by the effective divisor.
// After reset the back end clears all 2^(ORDER*SYMBOL_BITS+SYMBOL_BITS) table
// entries (65536 by default), one entry a cycle, before it takes a job. A
// stalled receiver holds the result; the front queue still takes up to two
// items meanwhile.
// ----------------------------------------------------------------------------
module context_model_counter_table_top #(
    parameter int COUNT_BITS  = cmct_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [cmct_pkg::SYM_W-1:0]       symbol,
    input  logic                             start_of_stream,
    input  logic [cmct_pkg::CTX_W-1:0]       query_context,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cmct_pkg::PROB_W-1:0]      probability,
    output logic [cmct_pkg::OUT_W-1:0]       event_count,
    output logic [cmct_pkg::OUT_W-1:0]       context_total,
    output logic                             zero_denominator,
    output logic                             table_reduced,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cmct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);
    import cmct_pkg::*;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [DIV_W-1:0]   divisor_reg;
    logic [ASIZE_W-1:0] asize_reg;
    logic               job_valid, job_ready;
    job_t               job;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 16'd256;
            divisor_reg <= 8'd2;
            asize_reg   <= 5'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALPHA:   alpha_reg   <= cfg_data[ALPHA_W-1:0];
                REG_DIVISOR: divisor_reg <= cfg_data[DIV_W-1:0];
                REG_ASIZE:   asize_reg   <= cfg_data[ASIZE_W-1:0];
                default:     ;
            endcase
        end
    end

    cmct_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .symbol          (symbol),
        .start_of_stream (start_of_stream),
        .query_context   (query_context),
        .job_valid       (job_valid),
        .job_ready       (job_ready),
        .job             (job)
    );

    cmct_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_valid        (job_valid),
        .job_ready        (job_ready),
        .job              (job),
        .alpha            (alpha_reg),
        .divisor          (divisor_reg),
        .asize            (asize_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .probability      (probability),
        .event_count      (event_count),
        .context_total    (context_total),
        .zero_denominator (zero_denominator),
        .table_reduced    (table_reduced)
    );

endmodule
